// ===== rtl/core/mqttrx_pkg.sv =====
package mqttrx_pkg;

  // Field widths
  localparam int LEN_W   = 28;
  localparam int TOPIC_W = 16;

  // Control packet types
  localparam logic [3:0] KIND_CONNACK = 4'd2;
  localparam logic [3:0] KIND_PUBLISH = 4'd3;
  localparam logic [3:0] KIND_SUBACK  = 4'd9;

  // Byte roles
  localparam logic [2:0] ROLE_HEADER    = 3'd0;
  localparam logic [2:0] ROLE_LENGTH    = 3'd1;
  localparam logic [2:0] ROLE_TOPIC_LEN = 3'd2;
  localparam logic [2:0] ROLE_TOPIC     = 3'd3;
  localparam logic [2:0] ROLE_PACKET_ID = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD   = 3'd5;
  localparam logic [2:0] ROLE_OTHER     = 3'd6;
  localparam logic [2:0] ROLE_IGNORED   = 3'd7;

  // Miscellaneous codes
  localparam logic [1:0] QOS_NONE      = 2'd0;
  localparam logic [1:0] QOS_ONE       = 2'd1;
  localparam logic [7:0] CODE_SHORT    = 8'hFF;
  localparam logic [2:0] LEN_BYTES_MAX = 3'd4;

  // One input beat
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_reset;
  } beat_t;

  // One result beat
  typedef struct packed {
    logic [2:0]         byte_role;
    logic [3:0]         packet_kind;
    logic [1:0]         publish_qos;
    logic               packet_end;
    logic [LEN_W-1:0]   remaining_length;
    logic               connected;
    logic [7:0]         connack_code;
    logic [7:0]         suback_code;
    logic               send_puback;
    logic [TOPIC_W-1:0] ack_packet_id;
    logic               malformed;
  } result_t;

endpackage

// ===== rtl/core/mqttrx_in_reg.sv =====
module mqttrx_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  mqttrx_pkg::beat_t  up_beat,
  output logic               dn_valid,
  input  logic               dn_ready,
  output mqttrx_pkg::beat_t  dn_beat
);

  logic              valid_r;
  mqttrx_pkg::beat_t beat_r;

  // Take a new beat when empty or when the held one moves on
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

  // Hold the received beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat_r <= up_beat;
    end
  end

endmodule

// ===== rtl/core/mqttrx_parser.sv =====
module mqttrx_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  mqttrx_pkg::beat_t   s_beat,
  output logic                m_valid,
  input  logic                m_ready,
  output mqttrx_pkg::result_t m_result
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [7:0]                     hdr_r, hdr_nxt;
  logic [mqttrx_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [2:0]                     idx_r, idx_nxt;
  logic [mqttrx_pkg::LEN_W-1:0]   body_r, body_nxt;
  logic [mqttrx_pkg::TOPIC_W-1:0] topic_r, topic_nxt;
  logic [mqttrx_pkg::TOPIC_W-1:0] pid_r, pid_nxt;
  logic [7:0]                     code_r, code_nxt;
  logic                           conn_r, conn_nxt;
  logic                           out_valid_r;
  mqttrx_pkg::result_t            res_r, res_nxt;

  logic [7:0]                     b;
  logic                           take;
  logic                           finish;
  logic                           malf;
  logic [2:0]                     role;
  logic [4:0]                     len_shift;
  logic [mqttrx_pkg::TOPIC_W:0]   tend;
  logic [mqttrx_pkg::TOPIC_W:0]   tend_f;
  logic [mqttrx_pkg::LEN_W-1:0]   tend_w;
  logic [1:0]                     qos_cur;
  logic [1:0]                     qos_out;
  logic [7:0]                     conn_code;
  logic [7:0]                     sub_code;
  logic                           puback;
  logic [mqttrx_pkg::TOPIC_W-1:0] ack_id;

  assign b       = s_beat.rx_byte;
  assign s_ready = !out_valid_r || m_ready;
  assign take    = s_valid && s_ready;
  assign m_valid = out_valid_r;
  assign m_result = res_r;

  // QoS of the packet under way
  assign qos_cur = (hdr_r[7:4] == mqttrx_pkg::KIND_PUBLISH) ? hdr_r[2:1]
                                                            : mqttrx_pkg::QOS_NONE;
  assign qos_out = (hdr_nxt[7:4] == mqttrx_pkg::KIND_PUBLISH) ? hdr_nxt[2:1]
                                                              : mqttrx_pkg::QOS_NONE;

  // End of topic within the body, and length-group shift
  assign tend      = (mqttrx_pkg::TOPIC_W+1)'(topic_r) + 17'd2;
  assign tend_w    = mqttrx_pkg::LEN_W'(tend);
  assign len_shift = 5'(idx_r[1:0]) * 5'd7;

  // Classify the byte and work out the next state
  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    body_nxt  = body_r;
    topic_nxt = topic_r;
    pid_nxt   = pid_r;
    code_nxt  = code_r;
    conn_nxt  = conn_r;
    role      = mqttrx_pkg::ROLE_HEADER;
    finish    = 1'b0;
    malf      = 1'b0;
    conn_code = '0;
    sub_code  = '0;
    puback    = 1'b0;
    ack_id    = '0;
    tend_f    = '0;

    if (s_beat.link_reset) begin
      phase_nxt = PH_HEADER;
      hdr_nxt   = '0;
      len_nxt   = '0;
      idx_nxt   = '0;
      body_nxt  = '0;
      topic_nxt = '0;
      pid_nxt   = '0;
      code_nxt  = '0;
      conn_nxt  = 1'b0;
      role      = mqttrx_pkg::ROLE_IGNORED;
    end else begin
      case (phase_r)
        PH_LENGTH: begin
          len_nxt = len_r | (mqttrx_pkg::LEN_W'(b[6:0]) << len_shift);
          idx_nxt = {1'b0, idx_r[1:0]} + 3'd1;
          role    = mqttrx_pkg::ROLE_LENGTH;
          if (b[7]) begin
            // Drop the packet after four length bytes with continuation
            if (idx_nxt >= mqttrx_pkg::LEN_BYTES_MAX) begin
              malf      = 1'b1;
              phase_nxt = PH_HEADER;
            end
          end else if (len_nxt == '0) begin
            finish = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          role = mqttrx_pkg::ROLE_OTHER;
          case (hdr_r[7:4])
            mqttrx_pkg::KIND_PUBLISH: begin
              if (body_r == '0) begin
                topic_nxt = {b, 8'h00};
                role      = mqttrx_pkg::ROLE_TOPIC_LEN;
              end else if (body_r == 28'd1) begin
                topic_nxt = topic_r | {8'h00, b};
                role      = mqttrx_pkg::ROLE_TOPIC_LEN;
              end else if (body_r < tend_w) begin
                role = mqttrx_pkg::ROLE_TOPIC;
              end else if (qos_cur != mqttrx_pkg::QOS_NONE && body_r < tend_w + 28'd2) begin
                if (body_r == tend_w) begin
                  pid_nxt = {b, 8'h00};
                end else begin
                  pid_nxt = pid_r | {8'h00, b};
                end
                role = mqttrx_pkg::ROLE_PACKET_ID;
              end else begin
                role = mqttrx_pkg::ROLE_PAYLOAD;
              end
            end
            mqttrx_pkg::KIND_CONNACK: begin
              if (body_r == 28'd1) begin
                code_nxt = b;
              end
            end
            mqttrx_pkg::KIND_SUBACK: begin
              if (body_r == 28'd2) begin
                code_nxt = b;
              end
            end
            default: begin
              role = mqttrx_pkg::ROLE_OTHER;
            end
          endcase
          body_nxt = body_r + 28'd1;
          if (body_nxt >= len_r) begin
            finish = 1'b1;
          end
        end
        default: begin
          // Fixed header: start a new packet
          hdr_nxt   = b;
          len_nxt   = '0;
          idx_nxt   = '0;
          body_nxt  = '0;
          topic_nxt = '0;
          pid_nxt   = '0;
          code_nxt  = '0;
          phase_nxt = PH_LENGTH;
          role      = mqttrx_pkg::ROLE_HEADER;
        end
      endcase

      // Report the outcome on the last byte of a packet
      if (finish) begin
        phase_nxt = PH_HEADER;
        tend_f    = (mqttrx_pkg::TOPIC_W+1)'(topic_nxt) + 17'd2;
        case (hdr_r[7:4])
          mqttrx_pkg::KIND_CONNACK: begin
            if (len_nxt >= 28'd2) begin
              conn_code = code_nxt;
              conn_nxt  = (code_nxt == 8'h00);
            end else begin
              conn_code = mqttrx_pkg::CODE_SHORT;
              conn_nxt  = 1'b0;
            end
          end
          mqttrx_pkg::KIND_SUBACK: begin
            sub_code = (len_nxt >= 28'd3) ? code_nxt : mqttrx_pkg::CODE_SHORT;
          end
          mqttrx_pkg::KIND_PUBLISH: begin
            if (len_nxt < 28'd2 || mqttrx_pkg::LEN_W'(tend_f) > len_nxt) begin
              malf = 1'b1;
            end else if (qos_cur == mqttrx_pkg::QOS_ONE &&
                         mqttrx_pkg::LEN_W'(tend_f) + 28'd2 <= len_nxt) begin
              puback = 1'b1;
              ack_id = pid_nxt;
            end
          end
          default: begin
            malf = 1'b0;
          end
        endcase
      end
    end

    res_nxt.byte_role        = role;
    res_nxt.packet_kind      = hdr_nxt[7:4];
    res_nxt.publish_qos      = qos_out;
    res_nxt.packet_end       = finish;
    res_nxt.remaining_length = len_nxt;
    res_nxt.connected        = conn_nxt;
    res_nxt.connack_code     = conn_code;
    res_nxt.suback_code      = sub_code;
    res_nxt.send_puback      = puback;
    res_nxt.ack_packet_id    = ack_id;
    res_nxt.malformed        = malf;
  end

  // Advance parser state and the result register on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hdr_r       <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      body_r      <= '0;
      topic_r     <= '0;
      pid_r       <= '0;
      code_r      <= '0;
      conn_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        hdr_r   <= hdr_nxt;
        len_r   <= len_nxt;
        idx_r   <= idx_nxt;
        body_r  <= body_nxt;
        topic_r <= topic_nxt;
        pid_r   <= pid_nxt;
        code_r  <= code_nxt;
        conn_r  <= conn_nxt;
        res_r   <= res_nxt;
      end
      if (s_ready) begin
        out_valid_r <= s_valid;
      end
    end
  end

endmodule

// ===== rtl/core/mqtt_receive_packet_parser_core.sv =====
// Channel  Direction  Handshake            Beat contents
// in_      input      in_valid / in_ready  in_rx_byte, in_link_reset
// out_     output     out_valid/out_ready  byte role, packet kind, QoS, end, length,
//                                          connected, CONNACK/SUBACK codes, PUBACK request
//
// One received byte per cycle while out_ready is high; after acceptance each byte's result
// passes the input register, then one pass of parse logic into the result register.
// The parse state registers update in that single pass; no byte waits on the one before.
// rst_n (synchronous, active low) empties both registers and returns to header wait.
// With out_ready low the result holds, the input register fills, then in_ready drops.
module mqtt_receive_packet_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_link_reset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_byte_role,
  output logic [3:0]  out_packet_kind,
  output logic [1:0]  out_publish_qos,
  output logic        out_packet_end,
  output logic [27:0] out_remaining_length,
  output logic        out_connected,
  output logic [7:0]  out_connack_code,
  output logic [7:0]  out_suback_code,
  output logic        out_send_puback,
  output logic [15:0] out_ack_packet_id,
  output logic        out_malformed
);

  mqttrx_pkg::beat_t   in_beat;
  mqttrx_pkg::beat_t   reg_beat;
  mqttrx_pkg::result_t res;
  logic                reg_valid;
  logic                reg_ready;

  assign in_beat.rx_byte    = in_rx_byte;
  assign in_beat.link_reset = in_link_reset;

  // Input register
  mqttrx_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_beat  (in_beat),
    .dn_valid (reg_valid),
    .dn_ready (reg_ready),
    .dn_beat  (reg_beat)
  );

  // Parse logic and result register
  mqttrx_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (reg_valid),
    .s_ready  (reg_ready),
    .s_beat   (reg_beat),
    .m_valid  (out_valid),
    .m_ready  (out_ready),
    .m_result (res)
  );

  assign out_byte_role        = res.byte_role;
  assign out_packet_kind      = res.packet_kind;
  assign out_publish_qos      = res.publish_qos;
  assign out_packet_end       = res.packet_end;
  assign out_remaining_length = res.remaining_length;
  assign out_connected        = res.connected;
  assign out_connack_code     = res.connack_code;
  assign out_suback_code      = res.suback_code;
  assign out_send_puback      = res.send_puback;
  assign out_ack_packet_id    = res.ack_packet_id;
  assign out_malformed        = res.malformed;

endmodule
